// ----- hdl/iirdz_pkg.sv -----
// Shared constants, types and register indexes for the dead-zone IIR filter.
// No dependencies; RTL files refer to it by scope and the testbench imports it.
`timescale 1ns / 1ps

package iirdz_pkg;

    localparam int FILTER_ORDER = 2;
    localparam int NTAPS        = FILTER_ORDER + 1;
    localparam int NTERMS       = NTAPS + FILTER_ORDER;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int BAND_W    = 16;
    localparam int CFG_W     = COEF_W;
    localparam int CFG_IDX_W = $clog2(2 * NTAPS + 1);

    // Register indexes on the configuration port.
    localparam int CFG_NUM_BASE  = 0;
    localparam int CFG_DEN_BASE  = NTAPS;
    localparam int CFG_DEAD_BAND = 2 * NTAPS;

    // Multiply-accumulate: one digit of the history value per cycle.
    localparam int ACC_W     = SAMPLE_W + COEF_W + $clog2(NTERMS);
    localparam int DIGIT_W   = 8;
    localparam int DIGITS    = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int TERM_W    = $clog2(NTERMS);
    localparam int SHAMT_W   = $clog2(SAMPLE_W);
    localparam int PROD_W    = COEF_W + DIGIT_W + 2;

    // Divider: quotient magnitude of Q_W bits, DIV_BITS bits per cycle.
    localparam int Q_W       = SAMPLE_W + 2;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = Q_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int R_W       = COEF_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        logic [Q_W-1:0] mag;
        logic           neg;
        logic           ovf;
    } div_res_t;

    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam coef_t COEF_ONE  = COEF_W'(16384);
    localparam coef_t COEF_ZERO = '0;

    localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [Q_W-1:0] SAT_POS_MAG = Q_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [Q_W-1:0] SAT_NEG_MAG = Q_W'(2 ** (SAMPLE_W - 1));

endpackage

// ----- hdl/iirdz_mac.sv -----
// Digit-serial multiply-accumulate over the numerator and feedback terms.
// Depends on iirdz_pkg.
`timescale 1ns / 1ps

module iirdz_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  iirdz_pkg::coef_t                      coef [iirdz_pkg::NTERMS],
    input  iirdz_pkg::sample_t                    data [iirdz_pkg::NTERMS],
    output logic                                  done,
    output logic signed [iirdz_pkg::ACC_W-1:0]    acc
);

    logic                                    busy_reg;
    logic                                    done_reg;
    logic [iirdz_pkg::TERM_W-1:0]            term_reg;
    logic [iirdz_pkg::DIG_CNT_W-1:0]         dig_reg;
    logic [iirdz_pkg::SAMPLE_W-1:0]          sreg_reg;
    logic signed [iirdz_pkg::ACC_W-1:0]      acc_reg;

    iirdz_pkg::coef_t                        coef_sel;
    logic signed [iirdz_pkg::COEF_W:0]       coef_ext;
    logic signed [iirdz_pkg::COEF_W:0]       coef_term;
    logic                                    digit_top;
    logic                                    last_term;
    logic signed [iirdz_pkg::DIGIT_W:0]      dval;
    logic signed [iirdz_pkg::PROD_W-1:0]     prod;
    logic signed [iirdz_pkg::ACC_W-1:0]      prod_ext;
    logic [iirdz_pkg::SHAMT_W-1:0]           shamt;
    logic signed [iirdz_pkg::ACC_W-1:0]      acc_next;
    logic [iirdz_pkg::TERM_W-1:0]            term_next;

    always_comb
    begin
        coef_sel = coef[term_reg];
        coef_ext = {coef_sel[iirdz_pkg::COEF_W-1], coef_sel};
        // Feedback terms are subtracted, so their coefficient enters negated.
        if (term_reg >= iirdz_pkg::TERM_W'(iirdz_pkg::NTAPS))
        begin
            coef_term = -coef_ext;
        end
        else
        begin
            coef_term = coef_ext;
        end
        digit_top = (dig_reg == iirdz_pkg::DIG_CNT_W'(iirdz_pkg::DIGITS - 1));
        last_term = (term_reg == iirdz_pkg::TERM_W'(iirdz_pkg::NTERMS - 1));
        // Only the most significant digit carries the sign weight.
        dval = {digit_top & sreg_reg[iirdz_pkg::DIGIT_W-1],
                sreg_reg[iirdz_pkg::DIGIT_W-1:0]};
        prod = coef_term * dval;
        prod_ext = {{(iirdz_pkg::ACC_W - iirdz_pkg::PROD_W){prod[iirdz_pkg::PROD_W-1]}}, prod};
        shamt = iirdz_pkg::SHAMT_W'(dig_reg) * iirdz_pkg::SHAMT_W'(iirdz_pkg::DIGIT_W);
        acc_next = acc_reg + (prod_ext <<< shamt);
        term_next = iirdz_pkg::TERM_W'(term_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            term_reg <= '0;
            dig_reg  <= '0;
            sreg_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                term_reg <= '0;
                dig_reg  <= '0;
                sreg_reg <= data[0];
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                if (digit_top)
                begin
                    dig_reg <= '0;
                    if (last_term)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        term_reg <= term_next;
                        sreg_reg <= data[term_next];
                    end
                end
                else
                begin
                    dig_reg  <= iirdz_pkg::DIG_CNT_W'(dig_reg + 1'b1);
                    sreg_reg <= sreg_reg >> iirdz_pkg::DIGIT_W;
                end
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ----- hdl/iirdz_div.sv -----
// Serial restoring divider on magnitudes, DIV_BITS quotient bits per cycle.
// Flags a quotient too large for the magnitude register. Depends on iirdz_pkg.
`timescale 1ns / 1ps

module iirdz_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [iirdz_pkg::ACC_W-1:0]    dividend,
    input  iirdz_pkg::coef_t                      divisor,
    output logic                                  done,
    output iirdz_pkg::div_res_t                   res
);

    localparam int HI_W  = iirdz_pkg::ACC_W - iirdz_pkg::Q_W;
    localparam int CMP_W = (HI_W > iirdz_pkg::R_W) ? HI_W : iirdz_pkg::R_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic                              neg_reg;
    logic                              ovf_reg;
    logic [iirdz_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [iirdz_pkg::R_W-1:0]         rem_reg;
    logic [iirdz_pkg::Q_W-1:0]         quo_reg;
    logic [iirdz_pkg::COEF_W-1:0]      vmag_reg;

    logic [iirdz_pkg::ACC_W-1:0]       dmag;
    logic [iirdz_pkg::COEF_W-1:0]      vmag;
    logic [HI_W-1:0]                   dhi;
    logic                              ovf_start;
    logic [iirdz_pkg::R_W-1:0]         v_ext;
    logic [iirdz_pkg::R_W-1:0]         r;
    logic [iirdz_pkg::Q_W-1:0]         q;
    logic [iirdz_pkg::R_W-1:0]         rem_next;
    logic [iirdz_pkg::Q_W-1:0]         quo_next;

    always_comb
    begin
        dmag = dividend[iirdz_pkg::ACC_W-1] ? (~unsigned'(dividend) + 1'b1)
                                            : unsigned'(dividend);
        vmag = divisor[iirdz_pkg::COEF_W-1] ? (~unsigned'(divisor) + 1'b1)
                                            : unsigned'(divisor);
        dhi = dmag[iirdz_pkg::ACC_W-1:iirdz_pkg::Q_W];
        // If the upper part already reaches the divisor, the quotient needs more bits.
        ovf_start = (CMP_W'(dhi) >= CMP_W'(vmag));
    end

    always_comb
    begin
        v_ext = {1'b0, vmag_reg};
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < iirdz_pkg::DIV_BITS; i++)
        begin
            r = {r[iirdz_pkg::R_W-2:0], q[iirdz_pkg::Q_W-1]};
            q = {q[iirdz_pkg::Q_W-2:0], 1'b0};
            if (r >= v_ext)
            begin
                r    = r - v_ext;
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            vmag_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                neg_reg  <= dividend[iirdz_pkg::ACC_W-1] ^ divisor[iirdz_pkg::COEF_W-1];
                ovf_reg  <= ovf_start;
                vmag_reg <= vmag;
                rem_reg  <= iirdz_pkg::R_W'(dhi);
                quo_reg  <= dmag[iirdz_pkg::Q_W-1:0];
                cnt_reg  <= '0;
                if (ovf_start)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= iirdz_pkg::DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == iirdz_pkg::DIV_CNT_W'(iirdz_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign res.mag = quo_reg;
    assign res.neg = neg_reg;
    assign res.ovf = ovf_reg;

endmodule

// ----- hdl/iir_filter_dead_zone.sv -----
// Top level of the second-order IIR filter with output dead zone.
// Depends on iirdz_pkg, iirdz_mac and iirdz_div.
`timescale 1ns / 1ps

// Usage:
// Input transactions (in_valid/in_stall) carry kind and sample. kind selects
// filtering one sample or clearing both histories. Each input transaction
// yields exactly one output transaction (out_valid/out_stall) with filtered,
// raw_output, held and saturated.
// A filter item passes through these steps in order: starting the digit-serial
// multiply-accumulate unit, the unit itself (two digits for each of five
// terms), starting the serial divider, the divider (setup, then 2 quotient bits
// per cycle), leaving it, and a final step that saturates, applies the dead
// zone and registers the result. A zero leading denominator skips the divider,
// an oversized quotient ends it after setup, and a clear item goes straight to
// the final step. One item is processed at a time; in_stall is high from
// acceptance until its result is written to the output register. The next item
// is accepted while that result still waits to be taken. If the receiver
// stalls, the result is held unchanged and a finished item waits in its last
// step until the output register is free. Reset clears both histories and the
// last output and loads the coefficient registers with unity gain and a dead
// band of zero. The user must write registers through cfg_write/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.

module iir_filter_dead_zone (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic signed [iirdz_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [iirdz_pkg::SAMPLE_W-1:0] filtered,
    output logic signed [iirdz_pkg::SAMPLE_W-1:0] raw_output,
    output logic                                 held,
    output logic                                 saturated,
    input  logic                                 cfg_write,
    input  logic [iirdz_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdz_pkg::CFG_W-1:0]          cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                          state_reg;
    iirdz_pkg::coef_t                num_reg [iirdz_pkg::NTAPS];
    iirdz_pkg::coef_t                den_reg [iirdz_pkg::NTAPS];
    logic [iirdz_pkg::BAND_W-1:0]    dead_band_reg;
    iirdz_pkg::sample_t              ih_reg [iirdz_pkg::NTAPS];
    iirdz_pkg::sample_t              oh_reg [iirdz_pkg::FILTER_ORDER];
    iirdz_pkg::sample_t              last_reg;
    logic                            mac_start_reg;
    logic                            div_start_reg;
    logic                            zero_div_reg;
    logic                            clr_reg;
    logic                            out_valid_reg;
    iirdz_pkg::sample_t              filtered_reg;
    iirdz_pkg::sample_t              raw_reg;
    logic                            held_reg;
    logic                            sat_reg;

    iirdz_pkg::coef_t                mac_coef [iirdz_pkg::NTERMS];
    iirdz_pkg::sample_t              mac_data [iirdz_pkg::NTERMS];
    logic                            mac_done;
    logic signed [iirdz_pkg::ACC_W-1:0] mac_acc;
    logic                            div_done;
    iirdz_pkg::div_res_t             div_res;

    logic                            in_fire;
    logic                            fin_fire;
    logic                            pos_sat;
    logic                            neg_sat;
    logic [iirdz_pkg::Q_W-1:0]       mag_neg;
    iirdz_pkg::sample_t              raw_val;
    logic                            sat_val;
    logic signed [iirdz_pkg::SAMPLE_W:0] diff;
    logic [iirdz_pkg::SAMPLE_W:0]    abs_diff;
    logic                            hold_val;
    logic                            hist_zero;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign fin_fire = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // Term order: current and older inputs, then the output history.
    always_comb
    begin
        for (int i = 0; i < iirdz_pkg::NTAPS; i++)
        begin
            mac_coef[i] = num_reg[i];
            mac_data[i] = ih_reg[i];
        end
        for (int i = 0; i < iirdz_pkg::FILTER_ORDER; i++)
        begin
            mac_coef[iirdz_pkg::NTAPS + i] = den_reg[i + 1];
            mac_data[iirdz_pkg::NTAPS + i] = oh_reg[i];
        end
    end

    iirdz_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start_reg),
        .coef  (mac_coef),
        .data  (mac_data),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    iirdz_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (mac_acc),
        .divisor  (den_reg[0]),
        .done     (div_done),
        .res      (div_res)
    );

    always_comb
    begin
        pos_sat = !div_res.neg && (div_res.ovf || (div_res.mag > iirdz_pkg::SAT_POS_MAG));
        neg_sat = div_res.neg && (div_res.ovf || (div_res.mag > iirdz_pkg::SAT_NEG_MAG));
        mag_neg = ~div_res.mag + 1'b1;
        if (zero_div_reg)
        begin
            raw_val = '0;
            sat_val = 1'b0;
        end
        else if (pos_sat)
        begin
            raw_val = iirdz_pkg::SAT_MAX;
            sat_val = 1'b1;
        end
        else if (neg_sat)
        begin
            raw_val = iirdz_pkg::SAT_MIN;
            sat_val = 1'b1;
        end
        else
        begin
            raw_val = div_res.neg ? mag_neg[iirdz_pkg::SAMPLE_W-1:0]
                                  : div_res.mag[iirdz_pkg::SAMPLE_W-1:0];
            sat_val = 1'b0;
        end
        diff     = {raw_val[iirdz_pkg::SAMPLE_W-1], raw_val}
                 - {last_reg[iirdz_pkg::SAMPLE_W-1], last_reg};
        abs_diff = diff[iirdz_pkg::SAMPLE_W] ? (~unsigned'(diff) + 1'b1) : unsigned'(diff);
        hold_val = (abs_diff < {1'b0, dead_band_reg});
    end

    always_comb
    begin
        hist_zero = 1'b1;
        for (int i = 0; i < iirdz_pkg::NTAPS; i++)
        begin
            hist_zero = hist_zero && (ih_reg[i] == '0);
        end
        for (int i = 0; i < iirdz_pkg::FILTER_ORDER; i++)
        begin
            hist_zero = hist_zero && (oh_reg[i] == '0);
        end
    end

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iirdz_pkg::NTAPS; i++)
            begin
                num_reg[i] <= (i == 0) ? iirdz_pkg::COEF_ONE : iirdz_pkg::COEF_ZERO;
                den_reg[i] <= (i == 0) ? iirdz_pkg::COEF_ONE : iirdz_pkg::COEF_ZERO;
            end
            dead_band_reg <= '0;
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < iirdz_pkg::NTAPS; i++)
            begin
                if (cfg_index == iirdz_pkg::CFG_IDX_W'(iirdz_pkg::CFG_NUM_BASE + i))
                begin
                    num_reg[i] <= cfg_data;
                end
                if (cfg_index == iirdz_pkg::CFG_IDX_W'(iirdz_pkg::CFG_DEN_BASE + i))
                begin
                    den_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == iirdz_pkg::CFG_IDX_W'(iirdz_pkg::CFG_DEAD_BAND))
            begin
                dead_band_reg <= cfg_data[iirdz_pkg::BAND_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < iirdz_pkg::NTAPS; i++)
            begin
                ih_reg[i] <= '0;
            end
            for (int i = 0; i < iirdz_pkg::FILTER_ORDER; i++)
            begin
                oh_reg[i] <= '0;
            end
            last_reg      <= '0;
            mac_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            zero_div_reg  <= 1'b0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            raw_reg       <= '0;
            held_reg      <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            mac_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall && !fin_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (kind == iirdz_pkg::KIND_CLEAR)
                        begin
                            for (int i = 0; i < iirdz_pkg::NTAPS; i++)
                            begin
                                ih_reg[i] <= '0;
                            end
                            for (int i = 0; i < iirdz_pkg::FILTER_ORDER; i++)
                            begin
                                oh_reg[i] <= '0;
                            end
                            clr_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            ih_reg[0] <= sample;
                            for (int i = 1; i < iirdz_pkg::NTAPS; i++)
                            begin
                                ih_reg[i] <= ih_reg[i - 1];
                            end
                            clr_reg       <= 1'b0;
                            zero_div_reg  <= 1'b0;
                            mac_start_reg <= 1'b1;
                            state_reg     <= ST_MAC;
                        end
                    end
                end
                ST_MAC:
                begin
                    if (mac_done)
                    begin
                        if (den_reg[0] == '0)
                        begin
                            zero_div_reg <= 1'b1;
                            state_reg    <= ST_FIN;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        if (clr_reg)
                        begin
                            filtered_reg <= last_reg;
                            raw_reg      <= '0;
                            held_reg     <= 1'b0;
                            sat_reg      <= 1'b0;
                        end
                        else
                        begin
                            oh_reg[0] <= raw_val;
                            for (int i = 1; i < iirdz_pkg::FILTER_ORDER; i++)
                            begin
                                oh_reg[i] <= oh_reg[i - 1];
                            end
                            if (!hold_val)
                            begin
                                last_reg <= raw_val;
                            end
                            filtered_reg <= hold_val ? last_reg : raw_val;
                            raw_reg      <= raw_val;
                            held_reg     <= hold_val;
                            sat_reg      <= sat_val;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign filtered   = filtered_reg;
    assign raw_output = raw_reg;
    assign held       = held_reg;
    assign saturated  = sat_reg;

    a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_MAC))
        else $error("multiply-accumulate finished outside its state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("output transaction raised outside the final step");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == iirdz_pkg::KIND_CLEAR)) |=> hist_zero)
        else $error("clear transaction left a history nonzero");

    a_hold_needs_band: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && held) |-> (dead_band_reg != '0))
        else $error("output held with a zero dead band");

endmodule

// ----- tb/iir_filter_dead_zone_tb.sv -----
// Self-checking testbench for the dead-zone IIR filter: directed and random transactions,
// checked against a cycle-free predictor of the filter. Depends on iirdz_pkg and the RTL.
`timescale 1ns / 1ps

module iir_filter_dead_zone_tb;

    import iirdz_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 25;
    localparam int RANDOM_PHASES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 30;
    localparam int MAX_REPORTS   = 200;
    localparam longint TIMEOUT_NS = 5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_DEAD_BAND + 1);

    typedef struct {
        logic    kind;
        sample_t sample;
    } filter_item_t;

    typedef struct {
        sample_t filtered;
        sample_t raw_output;
        logic    held;
        logic    saturated;
    } filter_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = KIND_FILTER;
    sample_t sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sample_t filtered;
    sample_t raw_output;
    logic held;
    logic saturated;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    iir_filter_dead_zone dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .raw_output (raw_output),
        .held       (held),
        .saturated  (saturated),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    filter_item_t   pending_items[$];
    filter_result_t expected_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic rx_hold = 1'b0;
    int error_count = 0;
    event hold_off_go;

    // Predictor copy of the coefficients and the filter state.
    int num_c[NTAPS];
    int den_c[NTAPS];
    int unsigned band = 0;
    int x_hist[NTAPS];
    int y_hist[FILTER_ORDER];
    int last_out = 0;

    initial
    begin
        for (int i = 0; i < NTAPS; i++)
        begin
            num_c[i] = 0;
            den_c[i] = 0;
            x_hist[i] = 0;
        end
        for (int i = 0; i < FILTER_ORDER; i++)
            y_hist[i] = 0;
        num_c[0] = 16384;
        den_c[0] = 16384;
    end

    function automatic filter_result_t filter_step(logic k, sample_t x);
        filter_result_t r;
        longint acc;
        longint q;
        longint gap;
        int i;
        r.held = 1'b0;
        r.saturated = 1'b0;
        if (k == KIND_CLEAR)
        begin
            for (i = 0; i < NTAPS; i++)
                x_hist[i] = 0;
            for (i = 0; i < FILTER_ORDER; i++)
                y_hist[i] = 0;
            r.filtered = sample_t'(last_out);
            r.raw_output = '0;
        end
        else
        begin
            for (i = NTAPS - 1; i > 0; i--)
                x_hist[i] = x_hist[i-1];
            x_hist[0] = int'(x);
            acc = 0;
            for (i = 0; i < NTAPS; i++)
                acc += longint'(num_c[i]) * longint'(x_hist[i]);
            for (i = 1; i < NTAPS; i++)
                acc -= longint'(den_c[i]) * longint'(y_hist[i-1]);
            q = 0;
            if (den_c[0] != 0)
            begin
                // SystemVerilog division truncates toward zero.
                q = acc / longint'(den_c[0]);
                if (q > longint'(SAT_MAX))
                begin
                    q = longint'(SAT_MAX);
                    r.saturated = 1'b1;
                end
                else if (q < longint'(SAT_MIN))
                begin
                    q = longint'(SAT_MIN);
                    r.saturated = 1'b1;
                end
            end
            for (i = FILTER_ORDER - 1; i > 0; i--)
                y_hist[i] = y_hist[i-1];
            y_hist[0] = int'(q);
            gap = q - longint'(last_out);
            if (gap < 0)
                gap = -gap;
            if (gap < longint'(band))
                r.held = 1'b1;
            else
                last_out = int'(q);
            r.filtered = sample_t'(last_out);
            r.raw_output = sample_t'(q);
        end
        return r;
    endfunction

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Sender: offers queued transactions and predicts each one at acceptance.
    always @(posedge clk)
    begin
        filter_item_t next_item;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(filter_step(kind, sample));
            if (!(in_valid && in_stall))
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    kind <= next_item.kind;
                    sample <= next_item.sample;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver: checks each output transaction and stalls at random.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual filtered %0d raw %0d",
                             $time, filtered, raw_output);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("filtered", want.filtered, filtered);
                check_field("raw_output", want.raw_output, raw_output);
                check_field("held", want.held, held);
                check_field("saturated", want.saturated, saturated);
            end
        end
        out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    always
    begin
        @(hold_off_go);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx < CFG_DEN_BASE)
            num_c[idx - CFG_NUM_BASE] = int'(coef_t'(data));
        else if (idx < CFG_DEAD_BAND)
            den_c[idx - CFG_DEN_BASE] = int'(coef_t'(data));
        else if (idx == CFG_DEAD_BAND)
            band = int'(data[BAND_W-1:0]);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_filter(int b0, int b1, int b2, int a0, int a1, int a2, int dz);
        write_reg(CFG_IDX_W'(CFG_NUM_BASE), b0);
        write_reg(CFG_IDX_W'(CFG_NUM_BASE + 1), b1);
        write_reg(CFG_IDX_W'(CFG_NUM_BASE + 2), b2);
        write_reg(CFG_IDX_W'(CFG_DEN_BASE), a0);
        write_reg(CFG_IDX_W'(CFG_DEN_BASE + 1), a1);
        write_reg(CFG_IDX_W'(CFG_DEN_BASE + 2), a2);
        write_reg(CFG_IDX_W'(CFG_DEAD_BAND), dz);
    endtask

    task automatic queue_item(logic k, int x);
        filter_item_t it;
        it.kind = k;
        it.sample = sample_t'(x);
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic int rand_sample();
        int v;
        case ($urandom_range(3))
            0: v = int'(sample_t'($urandom));
            1: v = int'($urandom_range(512)) - 256;
            2: v = int'($urandom_range(8000)) - 4000;
            default:
            begin
                case ($urandom_range(3))
                    0: v = int'(SAT_MAX);
                    1: v = int'(SAT_MIN);
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic random_config();
        int b[NTAPS];
        int a[NTAPS];
        int dz;
        int i;
        case ($urandom_range(4))
            0:
            begin
                for (i = 0; i < NTAPS; i++)
                begin
                    b[i] = int'(coef_t'($urandom));
                    a[i] = int'(coef_t'($urandom));
                end
            end
            1, 2:
            begin
                // Mostly stable low-gain sections, so the histories stay in range.
                for (i = 0; i < NTAPS; i++)
                    b[i] = int'($urandom_range(8192)) - 2048;
                a[0] = 16384 + int'($urandom_range(4096)) - 2048;
                a[1] = int'($urandom_range(16384)) - 8192;
                a[2] = int'($urandom_range(8192)) - 4096;
            end
            3:
            begin
                for (i = 0; i < NTAPS; i++)
                begin
                    b[i] = int'($urandom_range(32768)) - 16384;
                    a[i] = int'($urandom_range(8192)) - 4096;
                end
                a[0] = int'($urandom_range(64)) - 32;
            end
            default:
            begin
                for (i = 0; i < NTAPS; i++)
                begin
                    b[i] = int'(coef_t'($urandom));
                    a[i] = int'($urandom_range(8192)) - 4096;
                end
                a[0] = 0;
            end
        endcase
        case ($urandom_range(5))
            0, 1: dz = 0;
            2, 3: dz = int'($urandom_range(64));
            4: dz = int'($urandom_range(65535));
            default: dz = 65535;
        endcase
        load_filter(b[0], b[1], b[2], a[0], a[1], a[2], dz);
    endtask

    initial
    begin
        int phase;
        int n;
        bit long_hold;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting is unity gain with no dead band.
        queue_item(KIND_FILTER, 0);
        queue_item(KIND_FILTER, 32767);
        queue_item(KIND_FILTER, -32768);
        queue_item(KIND_FILTER, -1);
        queue_item(KIND_FILTER, 1);
        queue_item(KIND_CLEAR, -1);
        queue_item(KIND_FILTER, 777);
        wait_idle();

        // Extreme coefficients push both the feedforward and feedback paths to saturation.
        load_filter(131071, -131072, 16384, 16384, 131071, -131072, 0);
        queue_item(KIND_FILTER, 32767);
        queue_item(KIND_FILTER, -32768);
        queue_item(KIND_FILTER, 32767);
        queue_item(KIND_FILTER, 12);
        wait_idle();

        // A zero divisor forces the raw result to zero.
        write_reg(CFG_IDX_W'(CFG_DEN_BASE), 0);
        queue_item(KIND_FILTER, 5000);
        queue_item(KIND_FILTER, -3);
        queue_item(KIND_CLEAR, 0);
        wait_idle();

        // The most negative divisor checks sign handling and truncation toward zero.
        load_filter(16384, 0, 0, -131072, 0, 0, 0);
        queue_item(KIND_FILTER, 7);
        queue_item(KIND_FILTER, -7);
        queue_item(KIND_FILTER, 32767);
        wait_idle();

        // Dead band: changes just below the threshold hold, the threshold itself passes.
        load_filter(16384, 0, 0, 16384, 0, 0, 100);
        queue_item(KIND_FILTER, 1000);
        queue_item(KIND_FILTER, 1099);
        queue_item(KIND_FILTER, 1100);
        queue_item(KIND_FILTER, 1000);
        queue_item(KIND_CLEAR, 12345);
        queue_item(KIND_FILTER, -20000);
        wait_idle();

        // The widest band holds everything short of a full-scale swing.
        write_reg(CFG_IDX_W'(CFG_DEAD_BAND), 65535);
        write_reg(CFG_UNUSED, -1);
        queue_item(KIND_FILTER, -32768);
        queue_item(KIND_FILTER, 32767);
        queue_item(KIND_FILTER, 0);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_config();
            long_hold = (phase % 7 == 4);
            case (long_hold ? 0 : phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 27;
                    stall_pct = 27;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 8)
                    queue_item(KIND_CLEAR, rand_sample());
                else
                    queue_item(KIND_FILTER, rand_sample());
            end
            if (long_hold)
                -> hold_off_go;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_results.size());
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- iir_filter_dead_zone.f -----
hdl/iirdz_pkg.sv
hdl/iirdz_mac.sv
hdl/iirdz_div.sv
hdl/iir_filter_dead_zone.sv
tb/iir_filter_dead_zone_tb.sv
